[design/imusrq_pkg.sv]
// Shared types and constants of the IMU sample ring queue.
package imusrq_pkg;

   // Default number of entries held by the queue.
   localparam int unsigned DEPTH_DEFAULT = 16;

   // Width of the result fill level field.
   localparam int unsigned FILL_W = 5;

   // Item kind carried on the request tuser bit.
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // Result status codes carried on the response tuser bits.
   typedef enum logic [1:0] {
      STAT_PUSHED   = 2'd0,
      STAT_REJECTED = 2'd1,
      STAT_POPPED   = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   // One stored sample. The first declared member sits in the highest bits, so the
   // accelerometer x axis lands in bits 15:0.
   typedef struct packed {
      logic        [31:0] arrival;
      logic               stamp_ok;
      logic        [23:0] stamp;
      logic signed [15:0] gyro_z;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_x;
      logic signed [15:0] accel_z;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_x;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   // Beat widths, padded to whole bytes.
   localparam int unsigned REQ_DATA_W = ((ENTRY_W + 7) / 8) * 8;
   localparam int unsigned RSP_DATA_W = ((ENTRY_W + FILL_W + 1 + 7) / 8) * 8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request beat
      logic execute;   // apply the held item to the queue and load the result
   } cmd_type;

endpackage

[design/imusrq_ctrl.sv]
// Controller of the IMU sample ring queue: request and response handshakes.
module imusrq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output imusrq_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   // The result register may be reloaded when it is empty or being emptied.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The response is valid from the load until the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a waiting response");

   // Every accepted beat is executed before the next one is accepted.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_tready)
      else $error("second beat accepted before execution");

   // Each execution produces a valid response in the next cycle.
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_tvalid)
      else $error("execution without a response");

endmodule

[design/imusrq_dpath.sv]
// Datapath of the IMU sample ring queue: sample store, pointers and result register.
module imusrq_dpath #(
   parameter int unsigned QUEUE_DEPTH = imusrq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  imusrq_pkg::cmd_type                 cmd,
   input  logic [imusrq_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                                req_tuser,
   output logic [imusrq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                          rsp_tuser
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned PAD_W = imusrq_pkg::RSP_DATA_W - imusrq_pkg::ENTRY_W
                                   - imusrq_pkg::FILL_W - 1;

   // Held request.
   imusrq_pkg::entry_type item_ff;
   logic                  mode_ff;

   // Queue control.
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Sample store.
   logic [imusrq_pkg::ENTRY_W-1:0] entry_ram_ff [QUEUE_DEPTH];

   // Result register.
   imusrq_pkg::entry_type           entry_rd_ff;
   imusrq_pkg::status_type          status_ff, status_in;
   logic                            dropped_ff, dropped_in;
   logic [imusrq_pkg::FILL_W-1:0]   fill_ff;
   logic [31:0]                     fill_ext;

   logic all_zero;
   logic is_full;
   logic wr_en;
   logic rd_en;

   // Latch the request beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= imusrq_pkg::entry_type'(req_tdata[imusrq_pkg::ENTRY_W-1:0]);
         mode_ff <= req_tuser;
      end
   end

   assign all_zero = (item_ff.accel_x == '0) && (item_ff.accel_y == '0) &&
                     (item_ff.accel_z == '0) && (item_ff.gyro_x == '0) &&
                     (item_ff.gyro_y == '0) && (item_ff.gyro_z == '0);
   assign is_full  = (count_ff == CNT_W'(QUEUE_DEPTH));

   // Decide the operation and the next pointer values.
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      dropped_in = 1'b0;
      status_in  = imusrq_pkg::STAT_REJECTED;
      if (mode_ff == imusrq_pkg::MODE_PUSH) begin
         if (!all_zero) begin
            status_in = imusrq_pkg::STAT_PUSHED;
            wr_en     = cmd.execute;
            tail_in   = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
            if (is_full) begin
               // The oldest entry makes way; the count stays at the depth.
               dropped_in = 1'b1;
               head_in    = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      end else begin
         if (count_ff == '0) begin
            status_in = imusrq_pkg::STAT_EMPTY;
         end else begin
            status_in = imusrq_pkg::STAT_POPPED;
            rd_en     = cmd.execute;
            head_in   = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in  = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Store write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ram_ff[tail_ff] <= item_ff;
      end
   end

   // Store read port; the read data register is the result payload, zero unless popped.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (rd_en) begin
            entry_rd_ff <= imusrq_pkg::entry_type'(entry_ram_ff[head_ff]);
         end else begin
            entry_rd_ff <= '0;
         end
      end
   end

   // Low bits of the count after the item.
   assign fill_ext = 32'(count_in);

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= status_in;
         dropped_ff <= dropped_in;
         fill_ff    <= fill_ext[imusrq_pkg::FILL_W-1:0];
      end
   end

   assign rsp_tdata = {{PAD_W{1'b0}}, entry_rd_ff, fill_ff, dropped_ff};
   assign rsp_tuser = status_ff;

   // The count never exceeds the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   // An empty or full queue has its pointers together.
   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || is_full) |-> head_ff == tail_ff)
      else $error("pointers apart on empty or full queue");

   // Dropping the oldest entry only happens on a push that leaves the queue full.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.execute) && !$past(reset) && dropped_ff) |->
      (is_full && status_ff == imusrq_pkg::STAT_PUSHED))
      else $error("drop flag without a full queue");

endmodule

[design/imu_sample_ring_queue.sv]
// Top level of the IMU sample ring queue.
//
// A ring queue of six-axis IMU samples that drops its oldest entry when full.
// Request beats arrive on req_*: tuser selects push (0) or pop (1), tdata
// carries the sample. Each request yields exactly one response beat on rsp_*:
// tuser holds the status (pushed, rejected all-zero sample, popped, empty) and
// tdata holds the drop flag, the fill level and, for a pop, the oldest sample.
// A push whose six axes are all zero is rejected and leaves the queue as it is.
// An accepted beat is executed once the response register is free, and its
// response is loaded into that register by the execution.
// For each item the controller accepts, then executes with a single store
// access; it takes the next beat while a response still waits.
// If the receiver stalls, the response is held and the next request waits in
// the execute step until the response register is free.
// Reset empties the queue at once (pointers and count cleared); no clearing
// pass is needed, as stored samples are only read after being written.
module imu_sample_ring_queue #(
   parameter int unsigned QUEUE_DEPTH = imusrq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, stamp_in,
   // stamp_ok_in, arrival_in, zero fill
   input  logic [imusrq_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // dropped_oldest, fill_level, out_accel_x, out_accel_y, out_accel_z,
   // out_gyro_x, out_gyro_y, out_gyro_z, stamp_out, stamp_ok_out,
   // arrival_out, zero fill
   output logic [imusrq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [1:0]                        rsp_tuser
);

   imusrq_pkg::cmd_type cmd;

   // Handshake sequencing.
   imusrq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Queue storage and result formation.
   imusrq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

[test/testbench.sv]
// Self-checking testbench for the IMU sample ring queue: directed table, then random pushes and pops.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned RING_DEPTH    = imusrq_pkg::DEPTH_DEFAULT;
   localparam int unsigned REQ_W         = imusrq_pkg::REQ_DATA_W;
   localparam int unsigned RANDOM_PHASES = 9;
   localparam int unsigned PHASE_ITEMS   = 70;
   localparam int unsigned LONG_HOLD     = 120;
   localparam int unsigned REPORT_LIMIT  = 50;

   // One response beat as the queue should produce it.
   typedef struct {
      imusrq_pkg::status_type status;
      logic                   dropped;
      logic [4:0]             fill;
      imusrq_pkg::entry_type  sample;
   } outcome_type;

   // One row of the directed stimulus table.
   typedef struct {
      logic                  mode;
      imusrq_pkg::entry_type sample;
      int                    reps;
      bit                    randomise;
      bit                    typed;
      outcome_type           want;
   } row_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [imusrq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]           rsp_tuser;

   // Shadow copy of the ring held by the predictor.
   imusrq_pkg::entry_type ring_slots [RING_DEPTH];
   int unsigned ring_head  = 0;
   int unsigned ring_tail  = 0;
   int unsigned ring_count = 0;

   outcome_type pending_outcomes [$];
   row_type     directed_rows [$];
   int          mismatch_count = 0;
   int          beat_index     = 0;
   int          burst_left     = 0;
   bit          idle_enabled   = 1'b1;
   bit          hold_request   = 1'b0;

   imu_sample_ring_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Applies one push or pop to the shadow ring and returns the beat it should give.
   function automatic outcome_type apply_queue_item(input logic mode,
                                                    input imusrq_pkg::entry_type s);
      outcome_type r;
      r.status  = imusrq_pkg::STAT_PUSHED;
      r.dropped = 1'b0;
      r.sample  = '0;
      if (mode == imusrq_pkg::MODE_PUSH) begin
         if (s.accel_x == 0 && s.accel_y == 0 && s.accel_z == 0 &&
             s.gyro_x == 0 && s.gyro_y == 0 && s.gyro_z == 0) begin
            r.status = imusrq_pkg::STAT_REJECTED;
         end else begin
            // A full ring gives up its oldest sample first.
            if (ring_count >= RING_DEPTH) begin
               ring_head  = (ring_head + 1) % RING_DEPTH;
               ring_count = RING_DEPTH - 1;
               r.dropped  = 1'b1;
            end
            ring_slots[ring_tail] = s;
            ring_tail  = (ring_tail + 1) % RING_DEPTH;
            ring_count = ring_count + 1;
         end
      end else begin
         if (ring_count == 0) begin
            r.status = imusrq_pkg::STAT_EMPTY;
         end else begin
            r.status   = imusrq_pkg::STAT_POPPED;
            r.sample   = ring_slots[ring_head];
            ring_head  = (ring_head + 1) % RING_DEPTH;
            ring_count = ring_count - 1;
         end
      end
      r.fill = 5'(ring_count);
      return r;
   endfunction

   function automatic outcome_type typed_outcome(input imusrq_pkg::status_type status,
                                                 input logic dropped,
                                                 input logic [4:0] fill);
      outcome_type r;
      r.status  = status;
      r.dropped = dropped;
      r.fill    = fill;
      r.sample  = '0;
      return r;
   endfunction

   function automatic imusrq_pkg::entry_type make_sample(
      input logic signed [15:0] ax, ay, az, gx, gy, gz,
      input logic [23:0] stamp, input logic ok,
      input logic [31:0] arrival);
      imusrq_pkg::entry_type s;
      s.accel_x  = ax;
      s.accel_y  = ay;
      s.accel_z  = az;
      s.gyro_x   = gx;
      s.gyro_y   = gy;
      s.gyro_z   = gz;
      s.stamp    = stamp;
      s.stamp_ok = ok;
      s.arrival  = arrival;
      return s;
   endfunction

   function automatic logic signed [15:0] extreme_axis_value();
      case ($urandom_range(0, 4))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return 16'sh0001;
      endcase
   endfunction

   // Random sample: mostly full random, with some all-zero, single-axis and extreme frames.
   function automatic imusrq_pkg::entry_type random_sample();
      imusrq_pkg::entry_type s;
      s.accel_x  = 16'($urandom);
      s.accel_y  = 16'($urandom);
      s.accel_z  = 16'($urandom);
      s.gyro_x   = 16'($urandom);
      s.gyro_y   = 16'($urandom);
      s.gyro_z   = 16'($urandom);
      s.stamp    = 24'($urandom);
      s.stamp_ok = 1'($urandom_range(0, 1));
      s.arrival  = $urandom;
      case ($urandom_range(0, 9))
         0, 1: begin
            s.accel_x = '0;
            s.accel_y = '0;
            s.accel_z = '0;
            s.gyro_x  = '0;
            s.gyro_y  = '0;
            s.gyro_z  = '0;
            case ($urandom_range(0, 6))
               0: s.accel_x = extreme_axis_value();
               1: s.accel_y = extreme_axis_value();
               2: s.accel_z = extreme_axis_value();
               3: s.gyro_x  = extreme_axis_value();
               4: s.gyro_y  = extreme_axis_value();
               5: s.gyro_z  = extreme_axis_value();
               default: ;
            endcase
         end
         2: begin
            s.accel_x = extreme_axis_value();
            s.accel_y = extreme_axis_value();
            s.accel_z = extreme_axis_value();
            s.gyro_x  = extreme_axis_value();
            s.gyro_y  = extreme_axis_value();
            s.gyro_z  = extreme_axis_value();
            s.stamp   = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            s.arrival = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic add_row(input logic mode, input imusrq_pkg::entry_type sample, input int reps,
                          input bit randomise, input bit typed, input outcome_type want);
      row_type r;
      r.mode      = mode;
      r.sample    = sample;
      r.reps      = reps;
      r.randomise = randomise;
      r.typed     = typed;
      r.want      = want;
      directed_rows.push_back(r);
   endtask

   task automatic drive_noise();
      req_tvalid <= 1'b0;
      req_tuser  <= 1'($urandom_range(0, 1));
      req_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom};
   endtask

   // Offers one request beat, waits for it to be taken and records what it should give.
   task automatic offer_item(input logic mode, input imusrq_pkg::entry_type s, input bit typed,
                             input outcome_type want);
      outcome_type predicted;
      int          gap;
      if (idle_enabled && burst_left == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         drive_noise();
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 10);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_W'(s);
      do @(posedge clock); while (!req_tready);
      predicted = apply_queue_item(mode, s);
      pending_outcomes.push_back(typed ? want : predicted);
      if (burst_left > 0) burst_left--;
   endtask

   // Stops offering and waits until every outstanding beat has been returned.
   task automatic drain_results();
      @(negedge clock);
      drive_noise();
      while (pending_outcomes.size() != 0) @(negedge clock);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input longint unsigned got,
                              input longint unsigned want);
      if (got != want)
         report_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                   beat_index, name, got, want));
   endtask

   // Receiver: stalls on a changing pattern, with a long hold-off on request.
   initial begin
      int hold_left;
      int pattern_left;
      int pattern_kind;
      hold_left    = 0;
      pattern_left = 0;
      pattern_kind = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            if (pattern_left == 0) begin
               pattern_kind = $urandom_range(0, 3);
               pattern_left = $urandom_range(20, 120);
            end
            pattern_left--;
            case (pattern_kind)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Response checker: every taken beat is matched against the oldest expectation.
   always @(posedge clock) begin
      outcome_type           want;
      imusrq_pkg::entry_type got_sample;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_index));
         end else begin
            want       = pending_outcomes.pop_front();
            got_sample = rsp_tdata[6 +: imusrq_pkg::ENTRY_W];
            check_field("status", rsp_tuser, want.status);
            check_field("dropped_oldest", rsp_tdata[0], want.dropped);
            check_field("fill_level", rsp_tdata[5:1], want.fill);
            check_field("accel_x", got_sample.accel_x, want.sample.accel_x);
            check_field("accel_y", got_sample.accel_y, want.sample.accel_y);
            check_field("accel_z", got_sample.accel_z, want.sample.accel_z);
            check_field("gyro_x", got_sample.gyro_x, want.sample.gyro_x);
            check_field("gyro_y", got_sample.gyro_y, want.sample.gyro_y);
            check_field("gyro_z", got_sample.gyro_z, want.sample.gyro_z);
            check_field("stamp", got_sample.stamp, want.sample.stamp);
            check_field("stamp_ok", got_sample.stamp_ok, want.sample.stamp_ok);
            check_field("arrival", got_sample.arrival, want.sample.arrival);
         end
         beat_index++;
      end
   end

   // Stimulus: directed table, then random phases of pushes and pops.
   initial begin
      imusrq_pkg::entry_type zero_sample;
      imusrq_pkg::entry_type s;
      outcome_type           none;
      int                    push_pct;
      zero_sample = '0;
      none        = typed_outcome(imusrq_pkg::STAT_PUSHED, 1'b0, 5'd0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty pop, all-zero frames, extreme samples, draining past empty.
      add_row(imusrq_pkg::MODE_POP, zero_sample, 1, 0, 1,
              typed_outcome(imusrq_pkg::STAT_EMPTY, 1'b0, 5'd0));
      add_row(imusrq_pkg::MODE_PUSH, zero_sample, 1, 0, 1,
              typed_outcome(imusrq_pkg::STAT_REJECTED, 1'b0, 5'd0));
      add_row(imusrq_pkg::MODE_PUSH, make_sample(16'sh8000, '0, '0, '0, 16'sh8000, '0,
                                                 24'h000000, 1'b0, 32'h0000_0000),
              1, 0, 1, typed_outcome(imusrq_pkg::STAT_PUSHED, 1'b0, 5'd1));
      add_row(imusrq_pkg::MODE_PUSH, make_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                                 16'sh7FFF, 16'sh7FFF, 24'hFFFFFF, 1'b1,
                                                 32'hFFFF_FFFF),
              1, 0, 1, typed_outcome(imusrq_pkg::STAT_PUSHED, 1'b0, 5'd2));
      add_row(imusrq_pkg::MODE_PUSH, make_sample('0, '0, '0, '0, '0, 16'sh0001, 24'h000001,
                                                 1'b1, 32'h1),
              1, 0, 1, typed_outcome(imusrq_pkg::STAT_PUSHED, 1'b0, 5'd3));
      add_row(imusrq_pkg::MODE_PUSH, make_sample('0, '0, '0, '0, '0, '0, 24'hFFFFFF, 1'b1,
                                                 32'hFFFF_FFFF),
              1, 0, 1, typed_outcome(imusrq_pkg::STAT_REJECTED, 1'b0, 5'd3));
      add_row(imusrq_pkg::MODE_POP, zero_sample, 3, 0, 0, none);
      add_row(imusrq_pkg::MODE_POP, zero_sample, 1, 0, 1,
              typed_outcome(imusrq_pkg::STAT_EMPTY, 1'b0, 5'd0));
      // Fill the ring, overflow it once, then pop to see that the oldest went.
      add_row(imusrq_pkg::MODE_PUSH, zero_sample, RING_DEPTH, 1, 0, none);
      add_row(imusrq_pkg::MODE_PUSH, zero_sample, 1, 1, 1,
              typed_outcome(imusrq_pkg::STAT_PUSHED, 1'b1, 5'd16));
      add_row(imusrq_pkg::MODE_POP, zero_sample, 1, 0, 0, none);

      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps) begin
            s = directed_rows[i].sample;
            if (directed_rows[i].randomise) begin
               s = random_sample();
               s.gyro_x[0] = 1'b1;
            end
            offer_item(directed_rows[i].mode, s, directed_rows[i].typed, directed_rows[i].want);
         end
      end
      drain_results();

      // Random phases, each leaning towards filling, draining or a balance.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: push_pct = 75;
            1: push_pct = 50;
            2: push_pct = 30;
            default: push_pct = 90;
         endcase
         idle_enabled = (phase % 3 != 1);
         burst_left   = 0;
         if (phase == 4) begin
            // Long receiver hold-off while the sender keeps offering.
            idle_enabled = 1'b0;
            hold_request = 1'b1;
         end
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < push_pct)
               offer_item(imusrq_pkg::MODE_PUSH, random_sample(), 0, none);
            else
               offer_item(imusrq_pkg::MODE_POP, random_sample(), 0, none);
         end
         if (phase == 2 || phase == 5)
            drain_results();
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[imu_sample_ring_queue.f]
design/imusrq_pkg.sv
design/imusrq_ctrl.sv
design/imusrq_dpath.sv
design/imu_sample_ring_queue.sv
test/testbench.sv
